@@ rtl/amd_pkg.sv @@
// Shared types, constants and the Morse symbol table of the audio Morse decoder.
package amd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int GSIZE_W  = 12;
  localparam int AMP_W    = 15;
  localparam int THRESH_W = GSIZE_W + AMP_W;
  localparam int SUM_W    = 28;
  localparam int CHAR_W   = 7;
  localparam int CFG_W    = 15;
  localparam int IDX_W    = 2;

  localparam logic [IDX_W-1:0] REG_MODE       = 2'd0;
  localparam logic [IDX_W-1:0] REG_GROUP_SIZE = 2'd1;
  localparam logic [IDX_W-1:0] REG_AMP_LEVEL  = 2'd2;

  localparam logic [GSIZE_W-1:0] GROUP_SIZE_RST = 12'd960;
  localparam logic [AMP_W-1:0]   AMP_LEVEL_RST  = 15'd50;

  localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

  // event kinds carried from the grouping front to the symbol back end
  localparam logic EV_RUN   = 1'b0;
  localparam logic EV_CLEAR = 1'b1;

  typedef enum logic {
    MODE_CALIBRATE = 1'b0,
    MODE_DECODE    = 1'b1
  } amd_mode_t;

  typedef struct packed {
    logic [GSIZE_W-1:0]  group_size;
    logic [THRESH_W-1:0] thresh;
  } amd_grp_cfg_t;

  // element i of a symbol is bit i of marks, 1 for dash
  function automatic logic [CHAR_W-1:0] morse_lookup(logic [3:0] len, logic [7:0] marks);
    logic [CHAR_W-1:0] ch;
    case ({len, marks})
      {4'd2, 8'h02}: ch = 7'h41;
      {4'd4, 8'h01}: ch = 7'h42;
      {4'd4, 8'h05}: ch = 7'h43;
      {4'd3, 8'h01}: ch = 7'h44;
      {4'd1, 8'h00}: ch = 7'h45;
      {4'd4, 8'h04}: ch = 7'h46;
      {4'd3, 8'h03}: ch = 7'h47;
      {4'd4, 8'h00}: ch = 7'h48;
      {4'd2, 8'h00}: ch = 7'h49;
      {4'd4, 8'h0E}: ch = 7'h4A;
      {4'd3, 8'h05}: ch = 7'h4B;
      {4'd4, 8'h02}: ch = 7'h4C;
      {4'd2, 8'h03}: ch = 7'h4D;
      {4'd2, 8'h01}: ch = 7'h4E;
      {4'd3, 8'h07}: ch = 7'h4F;
      {4'd4, 8'h06}: ch = 7'h50;
      {4'd4, 8'h0B}: ch = 7'h51;
      {4'd3, 8'h02}: ch = 7'h52;
      {4'd3, 8'h00}: ch = 7'h53;
      {4'd1, 8'h01}: ch = 7'h54;
      {4'd3, 8'h04}: ch = 7'h55;
      {4'd4, 8'h08}: ch = 7'h56;
      {4'd3, 8'h06}: ch = 7'h57;
      {4'd4, 8'h09}: ch = 7'h58;
      {4'd4, 8'h0D}: ch = 7'h59;
      {4'd4, 8'h03}: ch = 7'h5A;
      {4'd5, 8'h1F}: ch = 7'h30;
      {4'd5, 8'h1E}: ch = 7'h31;
      {4'd5, 8'h1C}: ch = 7'h32;
      {4'd5, 8'h18}: ch = 7'h33;
      {4'd5, 8'h10}: ch = 7'h34;
      {4'd5, 8'h00}: ch = 7'h35;
      {4'd5, 8'h01}: ch = 7'h36;
      {4'd5, 8'h03}: ch = 7'h37;
      {4'd5, 8'h07}: ch = 7'h38;
      {4'd5, 8'h0F}: ch = 7'h39;
      {4'd6, 8'h2A}: ch = 7'h2E;
      {4'd6, 8'h33}: ch = 7'h2C;
      {4'd6, 8'h0C}: ch = 7'h3F;
      {4'd6, 8'h35}: ch = 7'h21;
      default:       ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/amd_fifo.sv @@
// Small first-word-fall-through queue with one or two writes and one read per cycle.
module amd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en0,
  input  logic                       wr_en1,
  input  logic [WIDTH-1:0]           wr_data0,
  input  logic [WIDTH-1:0]           wr_data1,
  input  logic                       rd_en,
  output logic [WIDTH-1:0]           rd_data,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wptr;
  logic [AW-1:0]    rptr;

  assign rd_data = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr_en0) begin
      mem[wptr] <= wr_data0;
    end
    if (wr_en1) begin
      mem[wptr + AW'(1)] <= wr_data1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      wptr  <= wptr + AW'(wr_en0) + AW'(wr_en1);
      rptr  <= rptr + AW'(rd_en);
      count <= count + CW'(wr_en0) + CW'(wr_en1) - CW'(rd_en);
    end
  end

endmodule

@@ rtl/amd_front.sv @@
// Front end: sample magnitude grouping, on/off level decision and run tracking.
module amd_front #(
  parameter int RUN_WIDTH = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                accept,
  input  logic signed [amd_pkg::SAMPLE_W-1:0] sample,
  input  logic                                first_of_pass,
  input  amd_pkg::amd_grp_cfg_t               grp_cfg,
  output logic                                ev_push,
  output logic [RUN_WIDTH+1:0]                ev_data
);

  import amd_pkg::*;

  localparam logic [RUN_WIDTH-1:0] RUN_MAX = {RUN_WIDTH{1'b1}};

  logic [SUM_W-1:0]     group_sum;
  logic [GSIZE_W-1:0]   group_count;
  logic                 current_level;
  logic [RUN_WIDTH-1:0] run_length;
  logic                 awaiting_first_group;

  logic [SUM_W-1:0]     sum_base;
  logic [GSIZE_W-1:0]   cnt_base;
  logic                 lvl_base;
  logic [RUN_WIDTH-1:0] run_base;
  logic                 await_base;
  logic [SAMPLE_W-1:0]  raw;
  logic [SAMPLE_W-1:0]  mag;
  logic [SUM_W-1:0]     sum_new;
  logic [GSIZE_W:0]     cnt_new;
  logic                 group_done;
  logic                 level;
  logic                 run_end;

  always_comb begin
    sum_base   = first_of_pass ? '0 : group_sum;
    cnt_base   = first_of_pass ? '0 : group_count;
    lvl_base   = first_of_pass ? 1'b0 : current_level;
    run_base   = first_of_pass ? '0 : run_length;
    await_base = first_of_pass | awaiting_first_group;
    raw        = sample;
    mag        = raw[SAMPLE_W-1] ? (~raw + SAMPLE_W'(1)) : raw;
    sum_new    = sum_base + SUM_W'(mag);
    cnt_new    = {1'b0, cnt_base} + (GSIZE_W+1)'(1);
    group_done = cnt_new >= {1'b0, grp_cfg.group_size};
    level      = sum_new > {1'b0, grp_cfg.thresh};
    run_end    = group_done & ~await_base & (level != lvl_base);
  end

  assign ev_push = accept & (first_of_pass | run_end);
  assign ev_data = first_of_pass ? {EV_CLEAR, 1'b0, {RUN_WIDTH{1'b0}}}
                                 : {EV_RUN, lvl_base, run_base};

  always_ff @(posedge clk) begin
    if (rst) begin
      group_sum            <= '0;
      group_count          <= '0;
      current_level        <= 1'b0;
      run_length           <= '0;
      awaiting_first_group <= 1'b1;
    end else if (accept) begin
      if (group_done) begin
        group_sum   <= '0;
        group_count <= '0;
        if (await_base) begin
          awaiting_first_group <= 1'b0;
          current_level        <= level;
          run_length           <= RUN_WIDTH'(1);
        end else if (level == lvl_base) begin
          awaiting_first_group <= 1'b0;
          current_level        <= lvl_base;
          run_length           <= (run_base == RUN_MAX) ? run_base : run_base + RUN_WIDTH'(1);
        end else begin
          awaiting_first_group <= 1'b0;
          current_level        <= level;
          run_length           <= RUN_WIDTH'(1);
        end
      end else begin
        group_sum            <= sum_new;
        group_count          <= cnt_new[GSIZE_W-1:0];
        current_level        <= lvl_base;
        run_length           <= run_base;
        awaiting_first_group <= await_base;
      end
    end
  end

endmodule

@@ rtl/amd_back.sv @@
// Back end: run-length statistics, dot/dash collection and character emission.
module amd_back #(
  parameter int SYMBOL_MAX = 6,
  parameter int RUN_WIDTH  = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  amd_pkg::amd_mode_t           mode,
  input  logic                         ev_go,
  input  logic [RUN_WIDTH+1:0]         ev_data,
  output logic                         wr_en0,
  output logic                         wr_en1,
  output logic [amd_pkg::CHAR_W:0]     wr_data0,
  output logic [amd_pkg::CHAR_W:0]     wr_data1
);

  import amd_pkg::*;

  localparam int LW = $clog2(SYMBOL_MAX + 1);

  logic [RUN_WIDTH-1:0]  min_off_run;
  logic [RUN_WIDTH-1:0]  max_off_run;
  logic [RUN_WIDTH-1:0]  min_on_run;
  logic [RUN_WIDTH-1:0]  max_on_run;
  logic [SYMBOL_MAX-1:0] symbol_marks;
  logic [LW-1:0]         symbol_length;
  logic                  symbol_overflow;

  logic                  ev_kind;
  logic                  ev_level;
  logic [RUN_WIDTH-1:0]  cnt;
  logic [RUN_WIDTH:0]    on_sum;
  logic                  is_dash;
  logic                  letter_gap;
  logic                  word_gap;
  logic [CHAR_W-1:0]     ch;
  logic                  has_ch;
  logic                  decode_off;

  always_comb begin
    ev_kind    = ev_data[RUN_WIDTH+1];
    ev_level   = ev_data[RUN_WIDTH];
    cnt        = ev_data[RUN_WIDTH-1:0];
    on_sum     = {1'b0, max_on_run} + {1'b0, min_on_run};
    is_dash    = cnt > on_sum[RUN_WIDTH:1];
    letter_gap = {1'b0, cnt} >= {min_off_run, 1'b0};
    word_gap   = ({1'b0, cnt} + {1'b0, min_off_run}) > {1'b0, max_off_run};
    ch         = morse_lookup(4'(symbol_length), 8'(symbol_marks));
    decode_off = ev_go & (ev_kind == EV_RUN) & (mode == MODE_DECODE) & ~ev_level;
    has_ch     = decode_off & letter_gap & ~symbol_overflow & (ch != CHAR_NONE);
    wr_en0     = has_ch | (decode_off & word_gap);
    wr_en1     = has_ch & word_gap;
    wr_data0   = has_ch ? {ch, ~word_gap} : {CHAR_SPACE, 1'b1};
    wr_data1   = {CHAR_SPACE, 1'b1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_off_run     <= '0;
      max_off_run     <= '0;
      min_on_run      <= '0;
      max_on_run      <= '0;
      symbol_marks    <= '0;
      symbol_length   <= '0;
      symbol_overflow <= 1'b0;
    end else if (ev_go) begin
      if (ev_kind == EV_CLEAR) begin
        symbol_marks    <= '0;
        symbol_length   <= '0;
        symbol_overflow <= 1'b0;
      end else if (mode == MODE_CALIBRATE) begin
        if (ev_level) begin
          if (cnt > max_on_run) begin
            max_on_run <= cnt;
          end
          if (cnt < min_on_run || min_on_run == '0) begin
            min_on_run <= cnt;
          end
        end else begin
          if (cnt > max_off_run) begin
            max_off_run <= cnt;
          end
          if (cnt < min_off_run || min_off_run == '0) begin
            min_off_run <= cnt;
          end
        end
      end else if (ev_level) begin
        if (symbol_length < LW'(SYMBOL_MAX)) begin
          symbol_marks  <= symbol_marks | (SYMBOL_MAX'(is_dash) << symbol_length);
          symbol_length <= symbol_length + LW'(1);
        end else begin
          symbol_overflow <= 1'b1;
        end
      end else if (letter_gap) begin
        symbol_marks    <= '0;
        symbol_length   <= '0;
        symbol_overflow <= 1'b0;
      end
    end
  end

endmodule

@@ rtl/audio_morse_decoder_top.sv @@
// Top level of the audio Morse decoder: config registers, front, event queue, back, result queue.
//
//  channel   direction  handshake            word
//  sample    in         push / full          sample, first_of_pass
//  result    out        empty / pop          char_code, last_in_run
//  config    in         cfg_write            cfg_index, cfg_data
//
//  One sample is taken per cycle while full is low; the front decides a group and a run end in that cycle.
//  A run end waits in the event queue for the back, which writes its words to the result queue.
//  The back handles one event per cycle while the result queue has room for two words.
//  full rises when the event queue is full; it follows pop stalls with a few words of slack.
//  Reset clears all run tracking, statistics and symbol state and loads the register defaults.
module audio_morse_decoder_top #(
  parameter int SYMBOL_MAX = 6,
  parameter int RUN_WIDTH  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic signed [amd_pkg::SAMPLE_W-1:0] sample,
  input  logic                                first_of_pass,
  output logic                                empty,
  input  logic                                pop,
  output logic [amd_pkg::CHAR_W-1:0]          char_code,
  output logic                                last_in_run,
  input  logic                                cfg_write,
  input  logic [amd_pkg::IDX_W-1:0]           cfg_index,
  input  logic [amd_pkg::CFG_W-1:0]           cfg_data
);

  import amd_pkg::*;

  localparam int EVQ_DEPTH = 4;
  localparam int OQ_DEPTH  = 4;
  localparam int EV_W      = RUN_WIDTH + 2;
  localparam int EVC_W     = $clog2(EVQ_DEPTH + 1);
  localparam int OQC_W     = $clog2(OQ_DEPTH + 1);

  amd_mode_t          mode;
  logic [GSIZE_W-1:0] group_size;
  logic [AMP_W-1:0]   amp_level;
  logic [GSIZE_W-1:0] group_size_next;
  logic [AMP_W-1:0]   amp_level_next;
  amd_grp_cfg_t       grp_cfg;

  logic               accept;
  logic               ev_push;
  logic [EV_W-1:0]    ev_in;
  logic [EV_W-1:0]    ev_out;
  logic [EVC_W-1:0]   evq_count;
  logic               ev_go;
  logic               oq_wr0;
  logic               oq_wr1;
  logic [CHAR_W:0]    oq_data0;
  logic [CHAR_W:0]    oq_data1;
  logic [CHAR_W:0]    oq_out;
  logic [OQC_W-1:0]   oq_count;
  logic               out_take;

  always_comb begin
    group_size_next = group_size;
    amp_level_next  = amp_level;
    if (cfg_write && cfg_index == REG_GROUP_SIZE) begin
      group_size_next = (cfg_data[GSIZE_W-1:0] == '0) ? GSIZE_W'(1) : cfg_data[GSIZE_W-1:0];
    end
    if (cfg_write && cfg_index == REG_AMP_LEVEL) begin
      amp_level_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_CALIBRATE;
      group_size     <= GROUP_SIZE_RST;
      amp_level      <= AMP_LEVEL_RST;
      grp_cfg.group_size <= GROUP_SIZE_RST;
      grp_cfg.thresh <= THRESH_W'(GROUP_SIZE_RST) * THRESH_W'(AMP_LEVEL_RST);
    end else begin
      if (cfg_write && cfg_index == REG_MODE) begin
        mode <= amd_mode_t'(cfg_data[0]);
      end
      group_size     <= group_size_next;
      amp_level      <= amp_level_next;
      grp_cfg.group_size <= group_size_next;
      grp_cfg.thresh <= THRESH_W'(group_size_next) * THRESH_W'(amp_level_next);
    end
  end

  assign full     = evq_count == EVC_W'(EVQ_DEPTH);
  assign accept   = push & ~full;
  assign ev_go    = (evq_count != '0) & (oq_count <= OQC_W'(OQ_DEPTH - 2));
  assign empty    = oq_count == '0;
  assign out_take = pop & ~empty;

  assign char_code   = oq_out[CHAR_W:1];
  assign last_in_run = oq_out[0];

  amd_front #(
    .RUN_WIDTH (RUN_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .sample        (sample),
    .first_of_pass (first_of_pass),
    .grp_cfg       (grp_cfg),
    .ev_push       (ev_push),
    .ev_data       (ev_in)
  );

  amd_fifo #(
    .WIDTH (EV_W),
    .DEPTH (EVQ_DEPTH)
  ) u_evq (
    .clk      (clk),
    .rst      (rst),
    .wr_en0   (ev_push),
    .wr_en1   (1'b0),
    .wr_data0 (ev_in),
    .wr_data1 ({EV_W{1'b0}}),
    .rd_en    (ev_go),
    .rd_data  (ev_out),
    .count    (evq_count)
  );

  amd_back #(
    .SYMBOL_MAX (SYMBOL_MAX),
    .RUN_WIDTH  (RUN_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .mode     (mode),
    .ev_go    (ev_go),
    .ev_data  (ev_out),
    .wr_en0   (oq_wr0),
    .wr_en1   (oq_wr1),
    .wr_data0 (oq_data0),
    .wr_data1 (oq_data1)
  );

  amd_fifo #(
    .WIDTH (CHAR_W + 1),
    .DEPTH (OQ_DEPTH)
  ) u_outq (
    .clk      (clk),
    .rst      (rst),
    .wr_en0   (oq_wr0),
    .wr_en1   (oq_wr1),
    .wr_data0 (oq_data0),
    .wr_data1 (oq_data1),
    .rd_en    (out_take),
    .rd_data  (oq_out),
    .count    (oq_count)
  );

  a_evq_bound: assert property (@(posedge clk) disable iff (rst)
    evq_count <= EVC_W'(EVQ_DEPTH))
    else $error("event queue count out of range");

  a_oq_bound: assert property (@(posedge clk) disable iff (rst)
    oq_count <= OQC_W'(OQ_DEPTH))
    else $error("result queue count out of range");

  a_pair_whole: assert property (@(posedge clk) disable iff (rst)
    (out_take && !last_in_run) |=> !empty)
    else $error("first word of a pair left without its partner");

  a_pair_written: assert property (@(posedge clk) disable iff (rst)
    oq_wr1 |-> oq_wr0 && !oq_data0[0])
    else $error("second result word without an open first word");

endmodule

@@ test/tb_top.sv @@
// Testbench for the audio Morse decoder: queued sample driver, result checker and decode model.
`timescale 1ns / 100ps

module tb_top;
  import amd_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MARKS_MAX    = 6;
  localparam int CODE_COUNT   = 40;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic                       restart;
  } sample_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } char_word_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       push = 1'b0;
  logic                       full;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       first_of_pass = 1'b0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic [CHAR_W-1:0]          char_code;
  logic                       last_in_run;
  logic                       cfg_write = 1'b0;
  logic [IDX_W-1:0]           cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data = '0;

  sample_word_t queued_samples [$];
  char_word_t   expected_chars [$];

  logic [CHAR_W-1:0] code_char [CODE_COUNT];
  logic [5:0]        code_marks [CODE_COUNT];
  int                code_len [CODE_COUNT];

  amd_mode_t          mode_cfg = MODE_CALIBRATE;
  logic [GSIZE_W-1:0] grp_cfg = GROUP_SIZE_RST;
  logic [AMP_W-1:0]   amp_cfg = AMP_LEVEL_RST;

  longint      acc_sum = 0;
  int          acc_count = 0;
  logic        level_now = 1'b0;
  logic [15:0] run_len = '0;
  logic        first_group = 1'b1;
  logic [15:0] off_min = '0;
  logic [15:0] off_max = '0;
  logic [15:0] on_min = '0;
  logic [15:0] on_max = '0;
  logic [5:0]  sym_marks = '0;
  logic [2:0]  sym_len = '0;
  logic        sym_over = 1'b0;

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  pass_opening = 1'b0;
  int  cycles = 0;
  int  mismatches = 0;
  int  n_samples = 0;
  int  n_words = 0;
  int  n_spaces = 0;
  int  n_writes = 0;

  audio_morse_decoder_top dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .sample       (sample),
    .first_of_pass(first_of_pass),
    .empty        (empty),
    .pop          (pop),
    .char_code    (char_code),
    .last_in_run  (last_in_run),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic decode_sample(input logic signed [SAMPLE_W-1:0] s, input logic restart);
    logic [16:0]       mag;
    logic [GSIZE_W-1:0] g;
    logic              lvl;
    logic [CHAR_W-1:0] found;
    logic [CHAR_W-1:0] outs [2];
    int                n;
    int                e;
    longint            letter_limit;
    longint            word_limit;
    char_word_t        w;
    n = 0;
    g = (grp_cfg == 0) ? 12'd1 : grp_cfg;
    if (restart) begin
      acc_sum = 0;
      acc_count = 0;
      level_now = 1'b0;
      run_len = '0;
      first_group = 1'b1;
      sym_marks = '0;
      sym_len = '0;
      sym_over = 1'b0;
    end
    mag = s[SAMPLE_W-1] ? 17'h10000 - {1'b0, s} : {1'b0, s};
    acc_sum += longint'(mag);
    acc_count++;
    if (acc_count >= g) begin
      lvl = acc_sum > longint'(g) * longint'(amp_cfg);
      acc_sum = 0;
      acc_count = 0;
      if (first_group) begin
        first_group = 1'b0;
        level_now = lvl;
        run_len = 16'd1;
      end else if (lvl == level_now) begin
        if (run_len != 16'hFFFF) run_len++;
      end else begin
        if (mode_cfg == MODE_CALIBRATE) begin
          if (level_now) begin
            if (run_len > on_max) on_max = run_len;
            if (run_len < on_min || on_min == 0) on_min = run_len;
          end else begin
            if (run_len > off_max) off_max = run_len;
            if (run_len < off_min || off_min == 0) off_min = run_len;
          end
        end else if (level_now) begin
          if (sym_len < MARKS_MAX) begin
            if (int'(run_len) > (int'(on_max) + int'(on_min)) / 2) sym_marks[sym_len] = 1'b1;
            sym_len++;
          end else begin
            sym_over = 1'b1;
          end
        end else begin
          letter_limit = 2 * longint'(off_min) - 1;
          word_limit = longint'(off_max) - longint'(off_min);
          if (longint'(run_len) > letter_limit) begin
            if (!sym_over) begin
              found = CHAR_NONE;
              for (e = 0; e < CODE_COUNT; e++) begin
                if (found == CHAR_NONE && code_len[e] == sym_len && code_marks[e] == sym_marks)
                  found = code_char[e];
              end
              if (found != CHAR_NONE) begin
                outs[n] = found;
                n++;
              end
            end
            sym_marks = '0;
            sym_len = '0;
            sym_over = 1'b0;
          end
          if (longint'(run_len) > word_limit) begin
            outs[n] = CHAR_SPACE;
            n++;
          end
        end
        level_now = lvl;
        run_len = 16'd1;
      end
    end
    for (e = 0; e < n; e++) begin
      w.ch = outs[e];
      w.last = (e == n - 1);
      expected_chars.push_back(w);
    end
  endtask

  // driver: hold the word until full drops
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        decode_sample(sample, first_of_pass);
        queued_samples.pop_front();
        n_samples++;
      end
      if (push && full) begin
        push <= 1'b1;
      end else if (queued_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        push <= 1'b1;
        sample <= queued_samples[0].value;
        first_of_pass <= queued_samples[0].restart;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        n_words++;
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected word char_code %h last_in_run %b", $time, char_code,
                   last_in_run);
          mismatches++;
        end else begin
          if (expected_chars[0].ch == CHAR_SPACE) n_spaces++;
          if (char_code !== expected_chars[0].ch || last_in_run !== expected_chars[0].last) begin
            $display("%0t: char_code expected %h got %h, last_in_run expected %b got %b",
                     $time, expected_chars[0].ch, char_code, expected_chars[0].last,
                     last_in_run);
            mismatches++;
          end
          expected_chars.pop_front();
        end
      end
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic wait_drained();
    while (queued_samples.size() != 0 || expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input int unsigned val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    case (idx)
      REG_MODE:       mode_cfg = amd_mode_t'(val[0]);
      REG_GROUP_SIZE: grp_cfg = val[GSIZE_W-1:0];
      REG_AMP_LEVEL:  amp_cfg = val[AMP_W-1:0];
      default:        ;
    endcase
    n_writes++;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic configure(input amd_mode_t m, input int g, input int amp, input int idle,
                           input int stall);
    wait_drained();
    write_reg(REG_MODE, m);
    write_reg(REG_GROUP_SIZE, g);
    write_reg(REG_AMP_LEVEL, amp);
    send_idle_pct = idle;
    recv_stall_pct = stall;
  endtask

  task automatic add_sample(input logic signed [SAMPLE_W-1:0] v);
    sample_word_t w;
    w.value = v;
    w.restart = pass_opening;
    pass_opening = 1'b0;
    queued_samples.push_back(w);
  endtask

  task automatic add_groups(input logic lvl, input int count);
    int                         gs;
    int                         mag;
    logic signed [SAMPLE_W-1:0] v;
    gs = (grp_cfg == 0) ? 1 : grp_cfg;
    repeat (count * gs) begin
      if (lvl) mag = $urandom_range(32768, amp_cfg + 1);
      else mag = $urandom_range(amp_cfg, 0);
      v = mag[15:0];
      if (mag != 32768 && $urandom_range(1)) v = -v;
      add_sample(v);
    end
  endtask

  function automatic int gap_groups(input bit word_gap);
    if (mode_cfg == MODE_CALIBRATE) return word_gap ? 7 : 3;
    return word_gap ? $urandom_range(12, 7) : $urandom_range(6, 2);
  endfunction

  task automatic add_pass(input int count);
    int         k;
    int         j;
    int         len;
    logic [7:0] marks;
    pass_opening = 1'b1;
    add_groups(1'b0, gap_groups(1'b1));
    for (k = 0; k < count; k++) begin
      if ($urandom_range(9) < 7) begin
        j = $urandom_range(CODE_COUNT - 1);
        len = code_len[j];
        marks = code_marks[j];
      end else begin
        len = $urandom_range(8, 1);
        marks = 8'($urandom);
      end
      for (j = 0; j < len; j++) begin
        if (mode_cfg == MODE_CALIBRATE) add_groups(1'b1, marks[j] ? 3 : 1);
        else add_groups(1'b1, marks[j] ? $urandom_range(5, 3) : $urandom_range(2, 1));
        add_groups(1'b0, (j == len - 1) ? gap_groups($urandom_range(3) == 0) : 1);
      end
    end
    add_groups(1'b1, 1);
  endtask

  task automatic add_noise(input int count);
    repeat (count) begin
      if ($urandom_range(3) == 0) begin
        add_groups(1'($urandom_range(1)), $urandom_range(8, 1));
      end else begin
        pass_opening = ($urandom_range(15) == 0);
        add_sample(SAMPLE_W'($urandom));
      end
    end
  endtask

  task automatic add_traffic(input int target);
    while (queued_samples.size() < target) begin
      if (mode_cfg == MODE_DECODE && $urandom_range(7) == 0) add_noise($urandom_range(20, 4));
      else add_pass($urandom_range(6, 1));
    end
  endtask

  initial begin : stimulus
    string      morse_text;
    int         i;
    int         k;
    int         len;
    logic [5:0] marks;
    morse_text = {"A.- B-... C-.-. D-.. E. F..-. G--. H.... I.. J.--- K-.- L.-.. M-- N-. ",
                  "O--- P.--. Q--.- R.-. S... T- U..- V...- W.-- X-..- Y-.-- Z--.. ",
                  "0----- 1.---- 2..--- 3...-- 4....- 5..... 6-.... 7--... 8---.. 9----. ",
                  "..-.-.- ,--..-- ?..--.. !-.-.--"};
    i = 0;
    k = 0;
    while (i < morse_text.len() && k < CODE_COUNT) begin
      code_char[k] = CHAR_W'(morse_text[i]);
      i++;
      marks = '0;
      len = 0;
      while (i < morse_text.len() && morse_text[i] != " ") begin
        if (morse_text[i] == "-") marks[len] = 1'b1;
        len++;
        i++;
      end
      code_len[k] = len;
      code_marks[k] = marks;
      k++;
      i++;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // decode with cleared statistics, threshold zero
    configure(MODE_DECODE, 1, 0, 0, 0);
    pass_opening = 1'b1;
    add_sample(16'sd0);
    add_sample(16'sd32767);
    add_sample(-16'sd32768);
    add_sample(16'sd0);
    add_sample(-16'sd1);
    pass_opening = 1'b1;
    add_sample(16'sd1);
    add_sample(16'sd0);

    // zero group size, top amplitude level
    configure(MODE_DECODE, 0, 32767, 0, 0);
    pass_opening = 1'b1;
    add_sample(16'sd32767);
    add_sample(-16'sd32768);
    add_sample(-16'sd32767);
    add_sample(-16'sd32768);
    add_sample(16'sd0);

    // calibrate: first statistics update from zero
    configure(MODE_CALIBRATE, 1, 100, 0, 0);
    pass_opening = 1'b1;
    add_sample(16'sd0);
    add_sample(16'sd150);
    add_sample(-16'sd101);
    add_sample(16'sd32767);
    add_sample(-16'sd100);
    add_sample(16'sd0);
    add_sample(16'sd100);
    add_sample(16'sd101);
    add_sample(16'sd0);

    configure(MODE_CALIBRATE, 2, 50, 0, 0);
    add_traffic(80);

    configure(MODE_DECODE, 1, 50, 0, 0);
    add_traffic(100);
    configure(MODE_DECODE, 2, 1000, 87, 0);
    add_traffic(100);
    configure(MODE_DECODE, 1, 12345, 0, 87);
    add_traffic(100);
    configure(MODE_DECODE, 1, 0, 26, 26);
    add_traffic(60);
    wait_drained();
    add_traffic(60);

    // widest group against a high level, left open
    configure(MODE_DECODE, 4095, 32000, 0, 0);
    pass_opening = 1'b1;
    repeat (30) add_sample(SAMPLE_W'($urandom));

    // scramble statistics, then decode against them
    configure(MODE_CALIBRATE, $urandom_range(4, 1), $urandom_range(3000), 0, 0);
    add_noise(20);
    configure(MODE_DECODE, $urandom_range(3, 1), $urandom_range(3000), 26, 26);
    add_traffic(80);

    wait_drained();
    $display("summary: %0d samples in, %0d words checked (%0d spaces), %0d register writes",
             n_samples, n_words, n_spaces, n_writes);
    $display("summary: calibrate and decode, group sizes 0 to 4095, levels 0 to 32767, %s",
             "overflowed symbols, idle and stall phases");
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/amd_pkg.sv
rtl/amd_fifo.sv
rtl/amd_front.sv
rtl/amd_back.sv
rtl/audio_morse_decoder_top.sv
test/tb_top.sv
